// ===== design/bvm_pkg.sv =====
// shared types, constants and fixed-point helpers for the battery voltage monitor
package bvm_pkg;

	localparam int unsigned ADC_FULL_SCALE_DEF      = 4095;
	localparam int unsigned DEFAULT_DIVIDER_Q16_DEF = 720896;
	localparam int unsigned Q16_3V3                 = 216269;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic signed [31:0] Q16_ONE     = 32'sd65536;
	localparam logic signed [31:0] GAIN_SELECT = -32'sd65536;
	localparam logic signed [31:0] S32_MAX     = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN     = 32'sh80000000;

	localparam logic [2:0] REG_DIVIDER_GAIN  = 3'd0;
	localparam logic [2:0] REG_FILTER_ALPHA  = 3'd1;
	localparam logic [2:0] REG_CELL_COUNT    = 3'd2;
	localparam logic [2:0] REG_CELL_MIN      = 3'd3;
	localparam logic [2:0] REG_CELL_MAX      = 3'd4;
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd5;

	typedef struct packed {
		logic signed [31:0] divider_gain;
		logic [16:0]        filter_alpha;
		logic [3:0]         cell_count;
		logic [19:0]        cell_min_volts;
		logic [19:0]        cell_max_volts;
		logic [31:0]        sample_period_us;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_us;
		logic [11:0] adc_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pack_volts;
		logic signed [31:0] smoothed_volts;
		logic [16:0]        charge_fraction;
	} out_item_t;

	typedef enum logic {
		DIV_VOLTS,
		DIV_FRAC
	} div_sel_t;

	typedef enum logic [1:0] {
		MUL_PACK,
		MUL_NEW,
		MUL_OLD
	} mul_op_t;

	typedef struct packed {
		logic     load_item;
		div_sel_t div_sel;
		logic     div_init;
		logic     div_step;
		logic     div_fin;
		mul_op_t  mul_op;
		logic     mul_prod;
		logic     mul_wb;
		logic     add_filt;
		logic     frac_clear;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic item_ok;
		logic in_range;
	} dp_status_t;

	function automatic logic [31:0] mag_of(input logic signed [31:0] x);
		return x[31] ? (32'd0 - $unsigned(x)) : $unsigned(x);
	endfunction

	function automatic logic signed [31:0] sat_mag(input logic neg, input logic [47:0] mag);
		if (neg) begin
			if (mag >= 48'h0000_8000_0000)
				return S32_MIN;
			return $signed(32'd0 - mag[31:0]);
		end
		if (mag > 48'h0000_7FFF_FFFF)
			return S32_MAX;
		return $signed(mag[31:0]);
	endfunction

endpackage

// ===== design/bvm_regs.sv =====
// apb configuration registers of the battery voltage monitor
module bvm_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bvm_pkg::ADDR_W-1:0]  paddr,
	input  logic [bvm_pkg::DATA_W-1:0]  pwdata,
	output logic [bvm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output bvm_pkg::cfg_t               cfg
);
	import bvm_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.divider_gain     <= GAIN_SELECT;
			cfg_q.filter_alpha     <= '0;
			cfg_q.cell_count       <= '0;
			cfg_q.cell_min_volts   <= '0;
			cfg_q.cell_max_volts   <= '0;
			cfg_q.sample_period_us <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_DIVIDER_GAIN:  cfg_q.divider_gain     <= $signed(pwdata);
				REG_FILTER_ALPHA:  cfg_q.filter_alpha     <= pwdata[16:0];
				REG_CELL_COUNT:    cfg_q.cell_count       <= pwdata[3:0];
				REG_CELL_MIN:      cfg_q.cell_min_volts   <= pwdata[19:0];
				REG_CELL_MAX:      cfg_q.cell_max_volts   <= pwdata[19:0];
				REG_SAMPLE_PERIOD: cfg_q.sample_period_us <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DIVIDER_GAIN:  prdata = $unsigned(cfg_q.divider_gain);
			REG_FILTER_ALPHA:  prdata = {15'd0, cfg_q.filter_alpha};
			REG_CELL_COUNT:    prdata = {28'd0, cfg_q.cell_count};
			REG_CELL_MIN:      prdata = {12'd0, cfg_q.cell_min_volts};
			REG_CELL_MAX:      prdata = {12'd0, cfg_q.cell_max_volts};
			REG_SAMPLE_PERIOD: prdata = cfg_q.sample_period_us;
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== design/bvm_datapath.sv =====
// datapath: sample gating, iterative divider, shared multiplier, filter and result register
module bvm_datapath #(
	parameter int unsigned ADC_FULL_SCALE      = bvm_pkg::ADC_FULL_SCALE_DEF,
	parameter int unsigned DEFAULT_DIVIDER_Q16 = bvm_pkg::DEFAULT_DIVIDER_Q16_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bvm_pkg::cfg_t        cfg,
	input  bvm_pkg::in_item_t    sample,
	input  bvm_pkg::dp_cmd_t     cmd,
	output bvm_pkg::dp_status_t  status,
	output bvm_pkg::out_item_t   result
);
	import bvm_pkg::*;

	localparam logic [63:0] RES_WIDE =
		((64'(ADC_FULL_SCALE) << 32) + 64'(Q16_3V3 / 2)) / 64'(Q16_3V3);
	localparam logic [31:0] RES =
		(RES_WIDE > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : RES_WIDE[31:0];
	localparam logic signed [31:0] DEF_GAIN = 32'(DEFAULT_DIVIDER_Q16);

	logic [31:0]        last_q;
	logic signed [31:0] filt_q;
	logic [11:0]        adc_q;
	logic [23:0]        vmin_q;
	logic [23:0]        vmax_q;
	logic [31:0]        quo_q;
	logic signed [31:0] pack_q;
	logic signed [31:0] t_new_q;
	logic signed [31:0] t_old_q;
	logic [16:0]        frac_q;
	logic [31:0]        rem_q;
	logic [31:0]        shf_q;
	logic [31:0]        dvs_q;
	logic               ovf_q;
	logic [63:0]        prod_q;
	logic               mneg_q;
	out_item_t          result_q;

	logic [31:0]        div_a;
	logic [31:0]        div_b;
	logic [47:0]        div_n;
	logic [32:0]        rem2;
	logic [32:0]        rem_sub;
	logic               ge;
	logic [31:0]        div_res;
	logic signed [31:0] gain;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic [63:0]        rnd;
	logic signed [31:0] mul_res;
	logic signed [32:0] sum;
	logic signed [31:0] sum_sat;
	logic [31:0]        elapsed;

	assign elapsed = sample.now_us - last_q;
	assign status.item_ok = (cfg.cell_count != 4'd0) && (elapsed > cfg.sample_period_us);
	assign status.in_range = (filt_q > $signed({8'd0, vmin_q}))
		&& (filt_q < $signed({8'd0, vmax_q}));

	assign gain = (cfg.divider_gain == GAIN_SELECT) ? DEF_GAIN : cfg.divider_gain;

	always_comb begin
		unique case (cmd.div_sel)
			DIV_VOLTS: begin
				div_a = {4'd0, adc_q, 16'd0};
				div_b = RES;
			end
			DIV_FRAC: begin
				div_a = $unsigned(filt_q) - {8'd0, vmin_q};
				div_b = {8'd0, vmax_q - vmin_q};
			end
		endcase
	end

	assign div_n   = {div_a, 16'd0} + {17'd0, div_b[31:1]};
	assign rem2    = {rem_q, shf_q[31]};
	assign rem_sub = rem2 - {1'b0, dvs_q};
	assign ge      = rem2 >= {1'b0, dvs_q};
	assign div_res = (ovf_q || shf_q[31]) ? 32'h7FFF_FFFF : shf_q;

	always_comb begin
		unique case (cmd.mul_op)
			MUL_PACK: begin
				mul_a = $signed(quo_q);
				mul_b = gain;
			end
			MUL_NEW: begin
				mul_a = Q16_ONE - $signed({15'd0, cfg.filter_alpha});
				mul_b = pack_q;
			end
			MUL_OLD: begin
				mul_a = $signed({15'd0, cfg.filter_alpha});
				mul_b = filt_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign rnd     = prod_q + 64'h8000;
	assign mul_res = sat_mag(mneg_q, rnd[63:16]);

	assign sum = {t_new_q[31], t_new_q} + {t_old_q[31], t_old_q};
	always_comb begin
		if (sum > 33'sh0_7FFF_FFFF)
			sum_sat = S32_MAX;
		else if (sum < -33'sh0_8000_0000)
			sum_sat = S32_MIN;
		else
			sum_sat = sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			filt_q <= '0;
		end else begin
			if (cmd.load_item)
				last_q <= sample.now_us;
			if (cmd.add_filt)
				filt_q <= sum_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			adc_q  <= sample.adc_sample;
			vmin_q <= 24'(cfg.cell_count) * 24'(cfg.cell_min_volts);
			vmax_q <= 24'(cfg.cell_count) * 24'(cfg.cell_max_volts);
		end
		if (cmd.div_init) begin
			rem_q <= {16'd0, div_n[47:32]};
			shf_q <= div_n[31:0];
			dvs_q <= div_b;
			ovf_q <= {16'd0, div_n[47:32]} >= div_b;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[31:0] : rem2[31:0];
			shf_q <= {shf_q[30:0], ge};
		end
		if (cmd.div_fin) begin
			if (cmd.div_sel == DIV_VOLTS)
				quo_q <= div_res;
			else
				frac_q <= div_res[16:0];
		end
		if (cmd.frac_clear)
			frac_q <= '0;
		if (cmd.mul_prod) begin
			prod_q <= 64'(mag_of(mul_a)) * 64'(mag_of(mul_b));
			mneg_q <= mul_a[31] ^ mul_b[31];
		end
		if (cmd.mul_wb) begin
			unique case (cmd.mul_op)
				MUL_PACK: pack_q  <= mul_res;
				MUL_NEW:  t_new_q <= mul_res;
				MUL_OLD:  t_old_q <= mul_res;
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			result_q.pack_volts      <= pack_q;
			result_q.smoothed_volts  <= filt_q;
			result_q.charge_fraction <= frac_q;
		end
	end

	assign result = result_q;

endmodule

// ===== design/bvm_ctrl.sv =====
// controller: sequences the divider, multiplier and filter steps and the result handshake
module bvm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  bvm_pkg::dp_status_t status,
	output bvm_pkg::dp_cmd_t    cmd
);
	import bvm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV1_INIT,
		S_DIV1_RUN,
		S_DIV1_FIN,
		S_PACK_P,
		S_PACK_W,
		S_NEW_P,
		S_NEW_W,
		S_OLD_P,
		S_OLD_W,
		S_ADD,
		S_RANGE,
		S_DIV2_INIT,
		S_DIV2_RUN,
		S_DIV2_FIN,
		S_DONE
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       valid_q;
	logic       out_free;

	assign out_free     = !valid_q || !result_stall;
	assign sample_stall = state_q != S_IDLE;
	assign result_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free)
				valid_q <= 1'b1;
			else if (valid_q && !result_stall)
				valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:
					if (sample_valid && status.item_ok)
						state_q <= S_DIV1_INIT;
				S_DIV1_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV1_RUN;
				end
				S_DIV1_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31)
						state_q <= S_DIV1_FIN;
				end
				S_DIV1_FIN:  state_q <= S_PACK_P;
				S_PACK_P:    state_q <= S_PACK_W;
				S_PACK_W:    state_q <= S_NEW_P;
				S_NEW_P:     state_q <= S_NEW_W;
				S_NEW_W:     state_q <= S_OLD_P;
				S_OLD_P:     state_q <= S_OLD_W;
				S_OLD_W:     state_q <= S_ADD;
				S_ADD:       state_q <= S_RANGE;
				S_RANGE:     state_q <= status.in_range ? S_DIV2_INIT : S_DONE;
				S_DIV2_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV2_RUN;
				end
				S_DIV2_RUN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31)
						state_q <= S_DIV2_FIN;
				end
				S_DIV2_FIN:  state_q <= S_DONE;
				S_DONE:
					if (out_free)
						state_q <= S_IDLE;
				default:     state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_VOLTS;
		cmd.mul_op  = MUL_PACK;
		unique case (state_q)
			S_IDLE:      cmd.load_item = sample_valid && status.item_ok;
			S_DIV1_INIT: cmd.div_init = 1'b1;
			S_DIV1_RUN:  cmd.div_step = 1'b1;
			S_DIV1_FIN:  cmd.div_fin = 1'b1;
			S_PACK_P:    cmd.mul_prod = 1'b1;
			S_PACK_W:    cmd.mul_wb = 1'b1;
			S_NEW_P: begin
				cmd.mul_op   = MUL_NEW;
				cmd.mul_prod = 1'b1;
			end
			S_NEW_W: begin
				cmd.mul_op = MUL_NEW;
				cmd.mul_wb = 1'b1;
			end
			S_OLD_P: begin
				cmd.mul_op   = MUL_OLD;
				cmd.mul_prod = 1'b1;
			end
			S_OLD_W: begin
				cmd.mul_op = MUL_OLD;
				cmd.mul_wb = 1'b1;
			end
			S_ADD:       cmd.add_filt = 1'b1;
			S_RANGE:     cmd.frac_clear = !status.in_range;
			S_DIV2_INIT: begin
				cmd.div_sel  = DIV_FRAC;
				cmd.div_init = 1'b1;
			end
			S_DIV2_RUN: begin
				cmd.div_sel  = DIV_FRAC;
				cmd.div_step = 1'b1;
			end
			S_DIV2_FIN: begin
				cmd.div_sel = DIV_FRAC;
				cmd.div_fin = 1'b1;
			end
			S_DONE:      cmd.load_out = out_free;
			default: ;
		endcase
	end

endmodule

// ===== design/battery_voltage_monitor_unit.sv =====
// top level of the battery voltage monitor
// Usage:
// - configure over the apb port while idle; registers sit at byte addresses 4*i,
//   in order divider_gain, filter_alpha, cell_count, cell_min_volts,
//   cell_max_volts, sample_period_us; pready is always high
// - a sample request (now_us, adc_sample) is taken when sample_valid is high and
//   sample_stall is low; a sample that comes too early or with cell_count zero
//   is taken and dropped, and the port is free again in the next cycle
// - a sample that passes gives one result request: between acceptance and
//   result_valid lie a restoring division for the pack voltage, the shared
//   multiplier products for the pack voltage and the filter terms, the filter
//   add, the range check and the result write; when the filtered voltage is
//   inside the charge range, a second restoring division for the charge fraction follows the range check
// - one sample is in work at a time; sample_stall is high from acceptance until
//   the result is written to the output register, so a new sample is taken only
//   once the result of the last one is in the output register
// - the output register holds a result while result_stall is high; the next
//   sample is accepted meanwhile and its result waits until the register frees
// - reset returns the configuration to its reset values, clears the filter
//   state and the last sample time, and drops any pending result
module battery_voltage_monitor_unit #(
	parameter int unsigned ADC_FULL_SCALE      = bvm_pkg::ADC_FULL_SCALE_DEF,
	parameter int unsigned DEFAULT_DIVIDER_Q16 = bvm_pkg::DEFAULT_DIVIDER_Q16_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bvm_pkg::ADDR_W-1:0]  paddr,
	input  logic [bvm_pkg::DATA_W-1:0]  pwdata,
	output logic [bvm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  bvm_pkg::in_item_t           sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output bvm_pkg::out_item_t          result
);
	import bvm_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	bvm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bvm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	bvm_datapath #(
		.ADC_FULL_SCALE      (ADC_FULL_SCALE),
		.DEFAULT_DIVIDER_Q16 (DEFAULT_DIVIDER_Q16)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule
